// File: design/colour_space_to_rgb_pixel_macros.svh
// Assertion helpers for the pixel converter; the clock and reset of the
// including module are i_clk and i_rst_n.
`ifndef COLOUR_SPACE_TO_RGB_PIXEL_MACROS_SVH
`define COLOUR_SPACE_TO_RGB_PIXEL_MACROS_SVH

// Same-cycle implication.
`define CSTR_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cstr_pkg.sv
package cstr_pkg;

    localparam int COMP_W = 24;
    localparam int NSTG   = 7;

    typedef enum logic [1:0] {
        CS_RGB     = 2'd0,
        CS_HSB     = 2'd1,
        CS_CMYK    = 2'd2,
        CS_UNKNOWN = 2'd3
    } t_cspace;

    typedef enum logic [1:0] {
        CFG_SPACE      = 2'd0,
        CFG_MASK_RED   = 2'd1,
        CFG_MASK_GREEN = 2'd2,
        CFG_MASK_BLUE  = 2'd3
    } t_cfg_idx;

    // Hue sectors; the magenta-to-red sector also takes hue 1.0.
    localparam logic [2:0] SEC_R_TO_Y = 3'd0;
    localparam logic [2:0] SEC_Y_TO_G = 3'd1;
    localparam logic [2:0] SEC_G_TO_C = 3'd2;
    localparam logic [2:0] SEC_C_TO_B = 3'd3;
    localparam logic [2:0] SEC_B_TO_M = 3'd4;

    localparam logic [7:0] MASK_RED_RST   = 8'd35;
    localparam logic [7:0] MASK_GREEN_RST = 8'd2;
    localparam logic [7:0] MASK_BLUE_RST  = 8'd20;

    // byte = floor(c * 25599 / (100 * ONE))
    localparam logic [14:0] QUANT_MUL = 15'd25599;
    localparam logic [14:0] QUANT_DIV = 15'd100;

    typedef struct packed {
        logic en_chroma;
        logic en_cross;
        logic en_sum;
    } t_hsb_ctl;

    typedef struct packed {
        logic en_mult;
        logic en_fix;
    } t_quant_ctl;

endpackage

// File: design/cstr_front.sv
module cstr_front #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  cstr_pkg::t_cspace                   i_space,
    input  logic signed [cstr_pkg::COMP_W-1:0]  i_comp_first,
    input  logic signed [cstr_pkg::COMP_W-1:0]  i_comp_second,
    input  logic signed [cstr_pkg::COMP_W-1:0]  i_comp_third,
    input  logic signed [cstr_pkg::COMP_W-1:0]  i_comp_fourth,
    output logic [FRACTION_BITS:0]              o_c0,
    output logic [FRACTION_BITS:0]              o_c1,
    output logic [FRACTION_BITS:0]              o_c2,
    output logic                                o_hsb
);
    import cstr_pkg::*;

    localparam int CW    = FRACTION_BITS + 1;
    localparam int EXT_W = ((FRACTION_BITS > COMP_W) ? FRACTION_BITS : COMP_W) + 3;
    localparam logic signed [EXT_W-1:0] ONE_W = {{(EXT_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic [CW-1:0]           ONE_C = {1'b1, {FRACTION_BITS{1'b0}}};

    logic signed [EXT_W-1:0] a_w, b_w, c_w, k_w;
    logic signed [EXT_W-1:0] pre0, pre1, pre2;
    logic [CW-1:0]           n_c0, n_c1, n_c2;
    logic [CW-1:0]           r_c0, r_c1, r_c2;
    logic                    r_hsb;

    function automatic logic [CW-1:0] clip01(input logic signed [EXT_W-1:0] v);
        logic [CW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > ONE_W) begin
            res = ONE_C;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    assign a_w = EXT_W'(i_comp_first);
    assign b_w = EXT_W'(i_comp_second);
    assign c_w = EXT_W'(i_comp_third);
    assign k_w = EXT_W'(i_comp_fourth);

    always_comb begin
        case (i_space)
            CS_CMYK: begin
                pre0 = ONE_W - (a_w + k_w);
                pre1 = ONE_W - (b_w + k_w);
                pre2 = ONE_W - (c_w + k_w);
            end
            CS_UNKNOWN: begin
                pre0 = '0;
                pre1 = '0;
                pre2 = '0;
            end
            default: begin
                pre0 = a_w;
                pre1 = b_w;
                pre2 = c_w;
            end
        endcase
        n_c0 = clip01(pre0);
        n_c1 = clip01(pre1);
        n_c2 = clip01(pre2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0  <= n_c0;
            r_c1  <= n_c1;
            r_c2  <= n_c2;
            r_hsb <= (i_space == CS_HSB);
        end
    end

    assign o_c0  = r_c0;
    assign o_c1  = r_c1;
    assign o_c2  = r_c2;
    assign o_hsb = r_hsb;

endmodule

// File: design/cstr_hsb.sv
module cstr_hsb #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  cstr_pkg::t_hsb_ctl     i_ctl,
    input  logic                   i_hsb,
    input  logic [FRACTION_BITS:0] i_c0,
    input  logic [FRACTION_BITS:0] i_c1,
    input  logic [FRACTION_BITS:0] i_c2,
    output logic [FRACTION_BITS:0] o_c0,
    output logic [FRACTION_BITS:0] o_c1,
    output logic [FRACTION_BITS:0] o_c2
);
    import cstr_pkg::*;

    localparam int CW = FRACTION_BITS + 1;
    localparam logic [CW:0] TWO_ONE = {1'b1, {CW{1'b0}}};

    // chroma stage
    logic [2*CW-1:0] n_sv;
    logic [CW+2:0]   n_h6;
    logic [CW-1:0]   n_low, n_w;
    logic [CW-1:0]   r_a_ch, r_a_w, r_a_c0, r_a_c1, r_a_c2;
    logic [2:0]      r_a_sec;
    logic            r_a_hsb;

    // cross stage
    logic [2*CW-1:0] n_cw;
    logic [CW-1:0]   r_b_ch, r_b_x, r_b_m, r_b_c0, r_b_c1, r_b_c2;
    logic [2:0]      r_b_sec;
    logic            r_b_hsb;

    // sum stage
    logic [CW-1:0]   sel_r, sel_g, sel_b;
    logic [CW:0]     sum_r, sum_g, sum_b;
    logic [CW-1:0]   n_o0, n_o1, n_o2;
    logic [CW-1:0]   r_o0, r_o1, r_o2;

    assign n_sv  = i_c1 * i_c2;
    assign n_h6  = (CW+3)'({i_c0, 2'b00}) + (CW+3)'({i_c0, 1'b0});
    assign n_low = n_h6[CW-1:0];
    // w = ONE - |(h6 mod 2*ONE) - ONE|
    assign n_w   = n_low[FRACTION_BITS] ? CW'(TWO_ONE - {1'b0, n_low}) : n_low;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_chroma) begin
            r_a_ch  <= n_sv[FRACTION_BITS +: CW];
            r_a_w   <= n_w;
            r_a_sec <= n_h6[FRACTION_BITS +: 3];
            r_a_c0  <= i_c0;
            r_a_c1  <= i_c1;
            r_a_c2  <= i_c2;
            r_a_hsb <= i_hsb;
        end
    end

    assign n_cw = r_a_ch * r_a_w;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_cross) begin
            r_b_ch  <= r_a_ch;
            r_b_x   <= n_cw[FRACTION_BITS +: CW];
            r_b_m   <= r_a_c2 - r_a_ch;
            r_b_sec <= r_a_sec;
            r_b_c0  <= r_a_c0;
            r_b_c1  <= r_a_c1;
            r_b_c2  <= r_a_c2;
            r_b_hsb <= r_a_hsb;
        end
    end

    always_comb begin
        case (r_b_sec)
            SEC_R_TO_Y: begin sel_r = r_b_ch; sel_g = r_b_x;  sel_b = '0;     end
            SEC_Y_TO_G: begin sel_r = r_b_x;  sel_g = r_b_ch; sel_b = '0;     end
            SEC_G_TO_C: begin sel_r = '0;     sel_g = r_b_ch; sel_b = r_b_x;  end
            SEC_C_TO_B: begin sel_r = '0;     sel_g = r_b_x;  sel_b = r_b_ch; end
            SEC_B_TO_M: begin sel_r = r_b_x;  sel_g = '0;     sel_b = r_b_ch; end
            default:    begin sel_r = r_b_ch; sel_g = '0;     sel_b = r_b_x;  end
        endcase
        sum_r = {1'b0, sel_r} + {1'b0, r_b_m};
        sum_g = {1'b0, sel_g} + {1'b0, r_b_m};
        sum_b = {1'b0, sel_b} + {1'b0, r_b_m};
        // sums never exceed brightness, so the top bit is always clear
        n_o0 = r_b_hsb ? sum_r[CW-1:0] : r_b_c0;
        n_o1 = r_b_hsb ? sum_g[CW-1:0] : r_b_c1;
        n_o2 = r_b_hsb ? sum_b[CW-1:0] : r_b_c2;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_o0 <= n_o0;
            r_o1 <= n_o1;
            r_o2 <= n_o2;
        end
    end

    assign o_c0 = r_o0;
    assign o_c1 = r_o1;
    assign o_c2 = r_o2;

endmodule

// File: design/cstr_quant.sv
module cstr_quant #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  cstr_pkg::t_quant_ctl   i_ctl,
    input  logic [FRACTION_BITS:0] i_c,
    output logic [7:0]             o_byte
);
    import cstr_pkg::*;

    localparam int CW = FRACTION_BITS + 1;
    localparam int PW = CW + 15;

    logic [CW+7:0] n_x255;
    logic [PW-1:0] n_prod;
    logic [7:0]    r_est;
    logic [PW-1:0] r_prod;
    logic [14:0]   n_inc;
    logic [PW-1:0] n_lim;
    logic [7:0]    r_byte;

    // floor(255c/ONE) is the answer or one short of it
    assign n_x255 = {i_c, 8'b0} - (CW+8)'(i_c);
    assign n_prod = PW'(i_c) * PW'(QUANT_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mult) begin
            r_est  <= n_x255[FRACTION_BITS +: 8];
            r_prod <= n_prod;
        end
    end

    assign n_inc = 15'(r_est) + 15'd1;
    assign n_lim = PW'(n_inc * QUANT_DIV) << FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_fix) begin
            r_byte <= r_est + 8'(n_lim <= r_prod);
        end
    end

    assign o_byte = r_byte;

endmodule

// File: design/colour_space_to_rgb_pixel.sv
// Converts one RGB, HSB or CMYK pixel (signed fixed point, FRACTION_BITS
// fraction bits) per clock into quantised 8-bit RGB. Throughput is one pixel
// every cycle while the output is not stalled. Beats pass one stage for
// space selection and clipping, three for the HSB chroma, cross product
// and sector sum, two for quantisation and one for the mask compare and
// output register. Stages advance independently, so an output stall only
// backs up the input once every stage holds a beat. Masked pixels return
// the mask colour; a converted colour that hits the mask colour leaves with
// blue raised by one. Registers are written through i_cfg_we/i_cfg_index/
// i_cfg_data and should only change while idle.
`include "colour_space_to_rgb_pixel_macros.svh"

module colour_space_to_rgb_pixel #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  cstr_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [cstr_pkg::COMP_W-1:0] i_comp_first,
    input  logic signed [cstr_pkg::COMP_W-1:0] i_comp_second,
    input  logic signed [cstr_pkg::COMP_W-1:0] i_comp_third,
    input  logic signed [cstr_pkg::COMP_W-1:0] i_comp_fourth,
    input  logic                               i_masked,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue
);
    import cstr_pkg::*;

    localparam int CW = FRACTION_BITS + 1;

    t_cspace       r_space;
    logic [7:0]    r_mask_red, r_mask_green, r_mask_blue;

    logic [NSTG-1:0] stg_en;
    logic [NSTG-1:0] r_vld, n_vld;
    logic [NSTG-1:0] r_msk, n_msk;

    logic [CW-1:0] f_c0, f_c1, f_c2, h_c0, h_c1, h_c2;
    logic          f_hsb;
    logic [7:0]    q_r, q_g, q_b;
    t_hsb_ctl      hsb_ctl;
    t_quant_ctl    quant_ctl;

    logic [7:0]    n_red, n_green, n_blue;
    logic [7:0]    r_red, r_green, r_blue;

    logic          out_masked;
    logic          out_is_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space      <= CS_RGB;
            r_mask_red   <= MASK_RED_RST;
            r_mask_green <= MASK_GREEN_RST;
            r_mask_blue  <= MASK_BLUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPACE:      r_space      <= t_cspace'(i_cfg_data[1:0]);
                CFG_MASK_RED:   r_mask_red   <= i_cfg_data;
                CFG_MASK_GREEN: r_mask_green <= i_cfg_data;
                CFG_MASK_BLUE:  r_mask_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage takes a new beat when it is empty or its own beat moves on.
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
        n_vld[0] = stg_en[0] ? i_valid  : r_vld[0];
        n_msk[0] = stg_en[0] ? i_masked : r_msk[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = stg_en[k] ? r_vld[k-1] : r_vld[k];
            n_msk[k] = stg_en[k] ? r_msk[k-1] : r_msk[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msk <= n_msk;
    end

    assign o_stall = !stg_en[0];

    assign hsb_ctl.en_chroma = stg_en[1];
    assign hsb_ctl.en_cross  = stg_en[2];
    assign hsb_ctl.en_sum    = stg_en[3];
    assign quant_ctl.en_mult = stg_en[4];
    assign quant_ctl.en_fix  = stg_en[5];

    cstr_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk         (i_clk),
        .i_en          (stg_en[0]),
        .i_space       (r_space),
        .i_comp_first  (i_comp_first),
        .i_comp_second (i_comp_second),
        .i_comp_third  (i_comp_third),
        .i_comp_fourth (i_comp_fourth),
        .o_c0          (f_c0),
        .o_c1          (f_c1),
        .o_c2          (f_c2),
        .o_hsb         (f_hsb)
    );

    cstr_hsb #(.FRACTION_BITS(FRACTION_BITS)) u_hsb (
        .i_clk (i_clk),
        .i_ctl (hsb_ctl),
        .i_hsb (f_hsb),
        .i_c0  (f_c0),
        .i_c1  (f_c1),
        .i_c2  (f_c2),
        .o_c0  (h_c0),
        .o_c1  (h_c1),
        .o_c2  (h_c2)
    );

    cstr_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_r (
        .i_clk  (i_clk),
        .i_ctl  (quant_ctl),
        .i_c    (h_c0),
        .o_byte (q_r)
    );

    cstr_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_g (
        .i_clk  (i_clk),
        .i_ctl  (quant_ctl),
        .i_c    (h_c1),
        .o_byte (q_g)
    );

    cstr_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant_b (
        .i_clk  (i_clk),
        .i_ctl  (quant_ctl),
        .i_c    (h_c2),
        .o_byte (q_b)
    );

    always_comb begin
        n_red   = q_r;
        n_green = q_g;
        n_blue  = q_b;
        if (r_msk[NSTG-2]) begin
            n_red   = r_mask_red;
            n_green = r_mask_green;
            n_blue  = r_mask_blue;
        end else if (q_r == r_mask_red && q_g == r_mask_green && q_b == r_mask_blue) begin
            // bump blue off the mask colour, wrapping at 255
            n_blue = q_b + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[NSTG-1]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    assign out_masked  = r_msk[NSTG-1];
    assign out_is_mask = (o_red == r_mask_red) && (o_green == r_mask_green)
                         && (o_blue == r_mask_blue);

    `CSTR_ASSERT_HOLDS(a_no_mask_hit, o_valid && !out_masked, !out_is_mask,
        "converted beat matches mask colour")
    `CSTR_ASSERT_HOLDS(a_masked_colour, o_valid && out_masked, out_is_mask,
        "masked beat lost mask colour")
    `CSTR_ASSERT_HOLDS(a_stall_only_full, o_stall, &r_vld,
        "input stalled with a free stage")
    `CSTR_ASSERT_NEXT(a_last_stage_moves, r_vld[NSTG-2] && stg_en[NSTG-1], o_valid,
        "quantised beat did not reach output")

endmodule

// File: bench/rgb_pixel_checker.sv
module rgb_pixel_checker
    import cstr_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  t_cfg_idx                  i_cfg_index,
    input  logic [7:0]                i_cfg_data,
    input  logic                      i_pix_valid,
    input  logic                      i_pix_stall,
    input  logic signed [COMP_W-1:0]  i_comp_first,
    input  logic signed [COMP_W-1:0]  i_comp_second,
    input  logic signed [COMP_W-1:0]  i_comp_third,
    input  logic signed [COMP_W-1:0]  i_comp_fourth,
    input  logic                      i_masked,
    input  logic                      i_rgb_valid,
    input  logic                      i_rgb_stall,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam longint ONE = longint'(1) << FRACTION_BITS;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    t_pixel     expected_pixels[$];
    t_cspace    space_cfg;
    logic [7:0] mask_red_cfg;
    logic [7:0] mask_green_cfg;
    logic [7:0] mask_blue_cfg;
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic longint clip_unit(longint c);
        if (c < 0) return 0;
        if (c > ONE) return ONE;
        return c;
    endfunction

    function automatic logic [7:0] to_byte(longint c);
        return 8'((clip_unit(c) * 25599) / (100 * ONE));
    endfunction

    function automatic t_pixel convert_pixel(
        longint c0, longint c1, longint c2, longint c3, logic masked
    );
        longint r, g, b;
        longint h, s, v, chroma, h6, sector, tri_dist, w, x, m;
        t_pixel p;
        if (masked) begin
            p.red   = mask_red_cfg;
            p.green = mask_green_cfg;
            p.blue  = mask_blue_cfg;
            return p;
        end
        r = c0;
        g = c1;
        b = c2;
        case (space_cfg)
            CS_RGB: begin
            end
            CS_HSB: begin
                h = clip_unit(c0);
                s = clip_unit(c1);
                v = clip_unit(c2);
                chroma = (s * v) >>> FRACTION_BITS;
                h6 = h * 6;
                sector = h6 >>> FRACTION_BITS;
                tri_dist = (h6 % (2 * ONE)) - ONE;
                if (tri_dist < 0) tri_dist = -tri_dist;
                w = ONE - tri_dist;
                x = (chroma * w) >>> FRACTION_BITS;
                m = v - chroma;
                // hue 1.0 lands in sector 6 and falls through to magenta-to-red
                case (sector)
                    SEC_R_TO_Y: begin r = chroma; g = x;      b = 0;      end
                    SEC_Y_TO_G: begin r = x;      g = chroma; b = 0;      end
                    SEC_G_TO_C: begin r = 0;      g = chroma; b = x;      end
                    SEC_C_TO_B: begin r = 0;      g = x;      b = chroma; end
                    SEC_B_TO_M: begin r = x;      g = 0;      b = chroma; end
                    default:    begin r = chroma; g = 0;      b = x;      end
                endcase
                r += m;
                g += m;
                b += m;
            end
            CS_CMYK: begin
                r = ONE - (c0 + c3);
                g = ONE - (c1 + c3);
                b = ONE - (c2 + c3);
            end
            default: begin
                r = 0;
                g = 0;
                b = 0;
            end
        endcase
        p.red   = to_byte(r);
        p.green = to_byte(g);
        p.blue  = to_byte(b);
        if (p.red == mask_red_cfg && p.green == mask_green_cfg && p.blue == mask_blue_cfg)
            p.blue = p.blue + 8'd1;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            space_cfg      <= CS_RGB;
            mask_red_cfg   <= MASK_RED_RST;
            mask_green_cfg <= MASK_GREEN_RST;
            mask_blue_cfg  <= MASK_BLUE_RST;
            expected_pixels.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SPACE:      space_cfg      <= t_cspace'(i_cfg_data[1:0]);
                    CFG_MASK_RED:   mask_red_cfg   <= i_cfg_data;
                    CFG_MASK_GREEN: mask_green_cfg <= i_cfg_data;
                    CFG_MASK_BLUE:  mask_blue_cfg  <= i_cfg_data;
                    default: ;
                endcase
            end
            // retire the output beat before queuing a new input beat
            if (i_rgb_valid && !i_rgb_stall) begin
                if (expected_pixels.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected pixel r=%0d g=%0d b=%0d with none outstanding",
                                 i_red, i_green, i_blue);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_red !== want.red || i_green !== want.green
                            || i_blue !== want.blue) begin
                        if (fail_count < 10)
                            $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     want.red, want.green, want.blue,
                                     i_red, i_green, i_blue);
                        fail_count++;
                    end
                end
            end
            if (i_pix_valid && !i_pix_stall)
                expected_pixels.push_back(convert_pixel(
                    longint'(i_comp_first), longint'(i_comp_second),
                    longint'(i_comp_third), longint'(i_comp_fourth), i_masked));
            o_pending <= expected_pixels.size();
        end
    end

endmodule

// File: bench/colour_space_to_rgb_pixel_tb.sv
module colour_space_to_rgb_pixel_tb;
    import cstr_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int ONE            = 1 << FRAC_BITS;
    localparam int PIXEL_TARGET   = 600;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic signed [COMP_W-1:0] COMP_MAX = 24'sh7FFFFF;
    localparam logic signed [COMP_W-1:0] COMP_MIN = 24'sh800000;
    localparam logic signed [COMP_W-1:0] COMP_ONE = COMP_W'(ONE);

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    t_cfg_idx                 i_cfg_index = CFG_SPACE;
    logic [7:0]               i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [COMP_W-1:0] i_comp_first = '0;
    logic signed [COMP_W-1:0] i_comp_second = '0;
    logic signed [COMP_W-1:0] i_comp_third = '0;
    logic signed [COMP_W-1:0] i_comp_fourth = '0;
    logic                     i_masked = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [7:0]               o_red;
    logic [7:0]               o_green;
    logic [7:0]               o_blue;

    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;
    int         send_calm = 0;
    int         recv_calm = 0;
    int         pixels_sent = 0;
    t_cspace    cur_space = CS_RGB;
    logic [7:0] cur_mask[3] = '{MASK_RED_RST, MASK_GREEN_RST, MASK_BLUE_RST};

    colour_space_to_rgb_pixel #(
        .FRACTION_BITS(FRAC_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_comp_first (i_comp_first),
        .i_comp_second(i_comp_second),
        .i_comp_third (i_comp_third),
        .i_comp_fourth(i_comp_fourth),
        .i_masked     (i_masked),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    rgb_pixel_checker #(
        .FRACTION_BITS(FRAC_BITS)
    ) pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (i_valid),
        .i_pix_stall  (o_stall),
        .i_comp_first (i_comp_first),
        .i_comp_second(i_comp_second),
        .i_comp_third (i_comp_third),
        .i_comp_fourth(i_comp_fourth),
        .i_masked     (i_masked),
        .i_rgb_valid  (o_valid),
        .i_rgb_stall  (i_stall),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Wait before a beat: mostly random, with bursts of back-to-back beats.
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Smallest component that quantizes to the given byte.
    function automatic logic signed [COMP_W-1:0] comp_for_byte(logic [7:0] k);
        return COMP_W'((longint'(k) * 100 * ONE + 25598) / 25599);
    endfunction

    function automatic logic signed [COMP_W-1:0] draw_comp();
        case ($urandom_range(0, 5))
            0:       return COMP_W'($urandom);
            1:       return '0;
            2:       return COMP_W'(ONE);
            3, 4:    return COMP_W'($urandom_range(0, ONE));
            default: return COMP_W'(int'($urandom_range(0, 3 * ONE)) - ONE);
        endcase
    endfunction

    function automatic logic [7:0] draw_mask_byte();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Output side: hold stall for a random number of cycles before each beat.
    initial begin
        int hold;
        wait (i_rst_n);
        forever begin
            hold = draw_wait(recv_calm);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    task automatic send_pixel(
        logic signed [COMP_W-1:0] c0, logic signed [COMP_W-1:0] c1,
        logic signed [COMP_W-1:0] c2, logic signed [COMP_W-1:0] c3, logic masked
    );
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_comp_first  <= c0;
        i_comp_second <= c1;
        i_comp_third  <= c2;
        i_comp_fourth <= c3;
        i_masked      <= masked;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
    endtask

    // Drain the pipe, then write all four registers.
    task automatic write_config(t_cspace space, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SPACE;
        i_cfg_data  <= {6'd0, space};
        @(posedge i_clk);
        i_cfg_index <= CFG_MASK_RED;
        i_cfg_data  <= r;
        @(posedge i_clk);
        i_cfg_index <= CFG_MASK_GREEN;
        i_cfg_data  <= g;
        @(posedge i_clk);
        i_cfg_index <= CFG_MASK_BLUE;
        i_cfg_data  <= b;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_space = space;
        cur_mask  = '{r, g, b};
    endtask

    initial begin
        int phase_len;
        int k;
        logic signed [COMP_W-1:0] t0, t1, t2;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: RGB pass-through, default mask
        send_pixel(0, 0, 0, 0, 1'b0);
        send_pixel(COMP_ONE, COMP_ONE, COMP_ONE, 0, 1'b0);
        send_pixel(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, 1'b0);
        send_pixel(COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, 1'b0);
        send_pixel(comp_for_byte(MASK_RED_RST), comp_for_byte(MASK_GREEN_RST),
                   comp_for_byte(MASK_BLUE_RST), 0, 1'b0);
        send_pixel(0, 0, 0, 0, 1'b1);

        // white against a white mask wraps blue to zero
        write_config(CS_RGB, 8'd255, 8'd255, 8'd255);
        send_pixel(COMP_ONE, COMP_ONE, COMP_ONE, COMP_MAX, 1'b0);
        send_pixel(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MIN, 1'b1);

        write_config(CS_HSB, 8'd0, 8'd0, 8'd0);
        send_pixel(0, COMP_ONE, COMP_ONE, 0, 1'b0);
        send_pixel(COMP_W'(ONE / 6), COMP_ONE, COMP_ONE, 0, 1'b0);
        send_pixel(COMP_W'(ONE / 2), COMP_ONE, COMP_ONE, COMP_MAX, 1'b0);
        send_pixel(COMP_ONE, COMP_ONE, COMP_ONE, 0, 1'b0);
        send_pixel(COMP_MAX, COMP_MAX, COMP_MAX, 0, 1'b0);
        send_pixel(COMP_MIN, COMP_W'(ONE / 2), COMP_ONE, 0, 1'b0);
        send_pixel(COMP_W'(ONE / 3), 0, COMP_ONE, 0, 1'b0);
        send_pixel(COMP_W'(ONE / 4), COMP_ONE, 0, 0, 1'b0);
        send_pixel(COMP_W'(5 * ONE / 6 + 100), COMP_W'(ONE / 2), COMP_W'(3 * ONE / 4), 0,
                   1'b0);

        write_config(CS_CMYK, 8'd255, 8'd0, 8'd128);
        send_pixel(0, 0, 0, 0, 1'b0);
        send_pixel(COMP_ONE, COMP_ONE, COMP_ONE, COMP_ONE, 1'b0);
        send_pixel(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MAX, 1'b0);
        send_pixel(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 1'b0);
        send_pixel(COMP_W'(ONE / 2), COMP_W'(ONE / 4), 0, COMP_W'(ONE / 8), 1'b0);

        // unknown space gives black, which collides with a black mask
        write_config(CS_UNKNOWN, 8'd0, 8'd0, 8'd0);
        send_pixel(COMP_ONE, COMP_MAX, COMP_MIN, COMP_ONE, 1'b0);
        send_pixel(COMP_ONE, COMP_ONE, COMP_ONE, COMP_ONE, 1'b1);

        while (pixels_sent < PIXEL_TARGET) begin
            write_config(t_cspace'($urandom_range(0, 3)), draw_mask_byte(),
                         draw_mask_byte(), draw_mask_byte());
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                case ($urandom_range(0, 7))
                    0: send_pixel(draw_comp(), draw_comp(), draw_comp(), draw_comp(), 1'b1);
                    1: begin
                        // aim the converted colour at the mask colour (in RGB and CMYK space)
                        t0 = comp_for_byte(cur_mask[0]);
                        t1 = comp_for_byte(cur_mask[1]);
                        t2 = comp_for_byte(cur_mask[2]);
                        if (cur_space == CS_CMYK) begin
                            k = $urandom_range(0, ONE);
                            send_pixel(COMP_W'(ONE - t0 - k), COMP_W'(ONE - t1 - k),
                                       COMP_W'(ONE - t2 - k), COMP_W'(k), 1'b0);
                        end else begin
                            send_pixel(t0, t1, t2, draw_comp(), 1'b0);
                        end
                    end
                    default: send_pixel(draw_comp(), draw_comp(), draw_comp(), draw_comp(),
                                        1'b0);
                endcase
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
